FILE: hdl/ddpi_pkg.sv
`default_nettype none

package ddpi_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned VLIM_W  = 15;
    localparam int unsigned INTEG_W = 32;
    localparam int unsigned MUL_A_W = 18;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RAD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VLIMIT    = 3'd6;

    // reset values
    localparam logic [FIELD_W-1:0] KP_RESET      = 16'd128;
    localparam logic [FIELD_W-1:0] KI_RESET      = 16'd0;
    localparam logic [FIELD_W-1:0] HALF_BASE_RST = 16'd0;
    localparam logic [FIELD_W-1:0] INV_RAD_RESET = 16'd256;
    localparam logic [VLIM_W-1:0]  VLIMIT_RESET  = 15'd32767;

    // sequencer states
    localparam int unsigned STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_IDLE = 4'd0;
    localparam logic [STATE_W-1:0] ST_TURN = 4'd1;
    localparam logic [STATE_W-1:0] ST_TL   = 4'd2;
    localparam logic [STATE_W-1:0] ST_TR   = 4'd3;
    localparam logic [STATE_W-1:0] ST_ER   = 4'd4;
    localparam logic [STATE_W-1:0] ST_KE   = 4'd5;
    localparam logic [STATE_W-1:0] ST_P    = 4'd6;
    localparam logic [STATE_W-1:0] ST_U    = 4'd7;
    localparam logic [STATE_W-1:0] ST_CHK  = 4'd8;
    localparam logic [STATE_W-1:0] ST_BACK = 4'd9;
    localparam logic [STATE_W-1:0] ST_REU  = 4'd10;
    localparam logic [STATE_W-1:0] ST_DRV  = 4'd11;
    localparam logic [STATE_W-1:0] ST_OUT  = 4'd12;

    function automatic logic signed [15:0] sat16(input logic signed [26:0] x);
        logic signed [15:0] r;
        if (x > 27'sd32767) begin
            r = 16'sh7FFF;
        end else if (x < -27'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ddpi_mul.sv
`default_nettype none

module ddpi_mul (
    input  wire logic                                     aclk,
    input  wire logic                                     en,
    input  wire logic signed [ddpi_pkg::MUL_A_W-1:0]      a,
    input  wire logic signed [ddpi_pkg::MUL_B_W-1:0]      b,
    output      logic signed [ddpi_pkg::PROD_W-1:0]       prod_reg
);

    logic signed [ddpi_pkg::PROD_W-1:0] prod_next;

    assign prod_next = ddpi_pkg::PROD_W'(a) * ddpi_pkg::PROD_W'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/diff_drive_dual_pi_controller.sv
`default_nettype none
// The sequencer walks every product through the single shared 18x17 multiplier; a
// wheel that backs out the integrator also passes the BACK and REU states. A new
// word is taken only in the idle state, once the last result is loaded; a result
// word not yet taken holds the sequencer in its output state.
// Reset: synchronous, active low; integrators and last errors clear to zero,
// registers load their defaults, no word is pending.

module diff_drive_dual_pi_controller (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   cfg_wr_en,
    input  wire logic [ddpi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ddpi_pkg::FIELD_W-1:0]           cfg_wr_data,

    input  wire logic                                   s_valid,
    output      logic                                   s_ready,
    input  wire logic signed [15:0]                     s_linear_speed_request,
    input  wire logic signed [15:0]                     s_turn_rate_request,
    input  wire logic signed [15:0]                     s_left_wheel_measured,
    input  wire logic signed [15:0]                     s_right_wheel_measured,

    output      logic                                   m_valid,
    input  wire logic                                   m_ready,
    output      logic signed [15:0]                     m_drive_left,
    output      logic signed [15:0]                     m_drive_right,
    output      logic signed [15:0]                     m_error_left,
    output      logic signed [15:0]                     m_error_right
);

    logic [ddpi_pkg::STATE_W-1:0] state_reg;
    logic                         side_reg;
    logic                         m_valid_reg;

    logic [15:0] kp_l_reg, kp_r_reg, ki_l_reg, ki_r_reg, hwb_reg, irad_reg;
    logic [ddpi_pkg::VLIM_W-1:0] vlim_reg;

    logic signed [15:0] v_reg, w_reg, ml_reg, mr_reg;
    logic signed [16:0] turn_reg;
    logic signed [15:0] el_reg, er_reg, last_l_reg, last_r_reg;
    logic signed [31:0] integ_l_reg, integ_r_reg;
    logic signed [32:0] p_reg;
    logic signed [33:0] u_reg;
    logic signed [15:0] drv_l_reg, drv_r_reg;
    logic signed [15:0] out_drv_l_reg, out_drv_r_reg, out_el_reg, out_er_reg;

    logic                                    mul_en;
    logic signed [ddpi_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [ddpi_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [ddpi_pkg::PROD_W-1:0]      prod;

    ddpi_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    logic signed [15:0] e_cur, last_cur;
    logic signed [31:0] integ_cur;
    logic [15:0]        kp_cur, ki_cur;
    logic signed [16:0] turn_now;
    logic signed [17:0] sum_l, diff_r;
    logic signed [25:0] tgt;
    logic signed [26:0] err_l_diff, err_r_diff;
    logic signed [24:0] inc;
    logic signed [32:0] integ_add;
    logic signed [25:0] back;
    logic signed [33:0] integ_sub;
    logic signed [33:0] u_new, u_re;
    logic signed [33:0] lim;
    logic               over, same_sign;
    logic signed [16:0] e_sum;
    logic signed [15:0] drive;
    logic               accept, out_load;

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ddpi_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    assign e_cur     = side_reg ? er_reg : el_reg;
    assign last_cur  = side_reg ? last_r_reg : last_l_reg;
    assign integ_cur = side_reg ? integ_r_reg : integ_l_reg;
    assign kp_cur    = side_reg ? kp_r_reg : kp_l_reg;
    assign ki_cur    = side_reg ? ki_r_reg : ki_l_reg;

    assign turn_now   = prod[32:16];
    assign sum_l      = {{2{v_reg[15]}}, v_reg} + {turn_now[16], turn_now};
    assign diff_r     = {{2{v_reg[15]}}, v_reg} - {turn_reg[16], turn_reg};
    assign tgt        = prod[33:8];
    assign err_l_diff = {tgt[25], tgt} - {{11{ml_reg[15]}}, ml_reg};
    assign err_r_diff = {tgt[25], tgt} - {{11{mr_reg[15]}}, mr_reg};

    assign inc       = prod[32:8];
    assign integ_add = {integ_cur[31], integ_cur} + {{8{inc[24]}}, inc};
    assign back      = prod[33:8];
    assign integ_sub = {{2{integ_cur[31]}}, integ_cur} - {{8{back[25]}}, back};

    assign u_new = {prod[32], prod[32:0]} + {{2{integ_cur[31]}}, integ_cur};
    assign u_re  = {p_reg[32], p_reg} + {{2{integ_cur[31]}}, integ_cur};

    assign lim       = {11'd0, vlim_reg, 8'd0};
    assign over      = u_reg[33] ? (u_reg < -lim) : (u_reg > lim);
    assign same_sign = (u_reg[33] == e_cur[15]);
    assign e_sum     = {e_cur[15], e_cur} + {last_cur[15], last_cur};
    assign drive     = ddpi_pkg::sat16({u_reg[33], u_reg[33:8]});

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ddpi_pkg::ST_TURN: begin
                mul_en = 1'b1;
                mul_a  = {{2{w_reg[15]}}, w_reg};
                mul_b  = {1'b0, hwb_reg};
            end
            ddpi_pkg::ST_TL: begin
                mul_en = 1'b1;
                mul_a  = sum_l;
                mul_b  = {1'b0, irad_reg};
            end
            ddpi_pkg::ST_TR: begin
                mul_en = 1'b1;
                mul_a  = diff_r;
                mul_b  = {1'b0, irad_reg};
            end
            ddpi_pkg::ST_KE: begin
                mul_en = 1'b1;
                mul_a  = {{2{e_cur[15]}}, e_cur};
                mul_b  = {1'b0, ki_cur};
            end
            ddpi_pkg::ST_P: begin
                mul_en = 1'b1;
                mul_a  = {{2{e_cur[15]}}, e_cur};
                mul_b  = {1'b0, kp_cur};
            end
            ddpi_pkg::ST_CHK: begin
                mul_en = 1'b1;
                mul_a  = {e_sum[16], e_sum};
                mul_b  = {1'b0, ki_cur};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ddpi_pkg::ST_IDLE;
            side_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            kp_l_reg    <= ddpi_pkg::KP_RESET;
            kp_r_reg    <= ddpi_pkg::KP_RESET;
            ki_l_reg    <= ddpi_pkg::KI_RESET;
            ki_r_reg    <= ddpi_pkg::KI_RESET;
            hwb_reg     <= ddpi_pkg::HALF_BASE_RST;
            irad_reg    <= ddpi_pkg::INV_RAD_RESET;
            vlim_reg    <= ddpi_pkg::VLIMIT_RESET;
            integ_l_reg <= '0;
            integ_r_reg <= '0;
            last_l_reg  <= '0;
            last_r_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ddpi_pkg::REG_KP_LEFT:   kp_l_reg <= cfg_wr_data;
                    ddpi_pkg::REG_KP_RIGHT:  kp_r_reg <= cfg_wr_data;
                    ddpi_pkg::REG_KI_LEFT:   ki_l_reg <= cfg_wr_data;
                    ddpi_pkg::REG_KI_RIGHT:  ki_r_reg <= cfg_wr_data;
                    ddpi_pkg::REG_HALF_BASE: hwb_reg  <= cfg_wr_data;
                    ddpi_pkg::REG_INV_RAD:   irad_reg <= cfg_wr_data;
                    ddpi_pkg::REG_VLIMIT:    vlim_reg <= cfg_wr_data[ddpi_pkg::VLIM_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ddpi_pkg::ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ddpi_pkg::ST_TURN;
                    end
                end
                ddpi_pkg::ST_TURN: state_reg <= ddpi_pkg::ST_TL;
                ddpi_pkg::ST_TL:   state_reg <= ddpi_pkg::ST_TR;
                ddpi_pkg::ST_TR:   state_reg <= ddpi_pkg::ST_ER;
                ddpi_pkg::ST_ER: begin
                    side_reg  <= 1'b0;
                    state_reg <= ddpi_pkg::ST_KE;
                end
                ddpi_pkg::ST_KE:   state_reg <= ddpi_pkg::ST_P;
                ddpi_pkg::ST_P: begin
                    if (side_reg) begin
                        integ_r_reg <= ddpi_pkg::sat32({integ_add[32], integ_add});
                    end else begin
                        integ_l_reg <= ddpi_pkg::sat32({integ_add[32], integ_add});
                    end
                    state_reg <= ddpi_pkg::ST_U;
                end
                ddpi_pkg::ST_U:    state_reg <= ddpi_pkg::ST_CHK;
                ddpi_pkg::ST_CHK: begin
                    if (over && same_sign) begin
                        state_reg <= ddpi_pkg::ST_BACK;
                    end else begin
                        state_reg <= ddpi_pkg::ST_DRV;
                    end
                end
                ddpi_pkg::ST_BACK: begin
                    if (side_reg) begin
                        integ_r_reg <= ddpi_pkg::sat32(integ_sub);
                    end else begin
                        integ_l_reg <= ddpi_pkg::sat32(integ_sub);
                    end
                    state_reg <= ddpi_pkg::ST_REU;
                end
                ddpi_pkg::ST_REU:  state_reg <= ddpi_pkg::ST_DRV;
                ddpi_pkg::ST_DRV: begin
                    if (side_reg) begin
                        last_r_reg <= e_cur;
                        state_reg  <= ddpi_pkg::ST_OUT;
                    end else begin
                        last_l_reg <= e_cur;
                        side_reg   <= 1'b1;
                        state_reg  <= ddpi_pkg::ST_KE;
                    end
                end
                ddpi_pkg::ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ddpi_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= ddpi_pkg::ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            v_reg  <= s_linear_speed_request;
            w_reg  <= s_turn_rate_request;
            ml_reg <= s_left_wheel_measured;
            mr_reg <= s_right_wheel_measured;
        end
        if (state_reg == ddpi_pkg::ST_TL) begin
            turn_reg <= turn_now;
        end
        if (state_reg == ddpi_pkg::ST_TR) begin
            el_reg <= ddpi_pkg::sat16(err_l_diff);
        end
        if (state_reg == ddpi_pkg::ST_ER) begin
            er_reg <= ddpi_pkg::sat16(err_r_diff);
        end
        if (state_reg == ddpi_pkg::ST_U) begin
            p_reg <= prod[32:0];
            u_reg <= u_new;
        end
        if (state_reg == ddpi_pkg::ST_REU) begin
            u_reg <= u_re;
        end
        if (state_reg == ddpi_pkg::ST_DRV) begin
            if (side_reg) begin
                drv_r_reg <= drive;
            end else begin
                drv_l_reg <= drive;
            end
        end
        if (out_load) begin
            out_drv_l_reg <= drv_l_reg;
            out_drv_r_reg <= drv_r_reg;
            out_el_reg    <= el_reg;
            out_er_reg    <= er_reg;
        end
    end

    assign s_ready       = (state_reg == ddpi_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_drive_left  = out_drv_l_reg;
    assign m_drive_right = out_drv_r_reg;
    assign m_error_left  = out_el_reg;
    assign m_error_right = out_er_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ddpi_pkg::ST_TURN))
        else $error("accepted word did not start the sequence");

    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && state_reg == ddpi_pkg::ST_IDLE))
        else $error("result load did not raise valid");

    a_left_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddpi_pkg::ST_ER) |=> (!side_reg && state_reg == ddpi_pkg::ST_KE))
        else $error("wheel sequence did not start on the left");

    a_back_after_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddpi_pkg::ST_BACK) |-> ($past(state_reg) == ddpi_pkg::ST_CHK))
        else $error("back-out entered out of order");
`endif

endmodule

`default_nettype wire
